>>> rtl/core/fts_pkg.sv
// Package for the binary indexed tree sum engine.
// Holds field widths, parameter defaults, the request codes and the adder control type.
// No dependencies.
`timescale 1ns / 1ps

package fts_pkg;

    localparam int IDX_W             = 11;
    localparam int LEN_W             = 11;
    localparam int IN_VALUE_W        = 32;
    localparam int TREE_SIZE_DEFAULT = 1024;
    localparam int VALUE_W_DEFAULT   = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    typedef enum logic [1:0] {
        OP_POINT_ADD = 2'd0,
        OP_PREFIX    = 2'd1,
        OP_RANGE_SUM = 2'd2,
        OP_RANGE_ADD = 2'd3
    } t_op;

    // update: tree entry plus value (write-back); otherwise accumulator plus entry.
    // subtract: the second operand is taken away instead of added.
    typedef struct packed {
        logic update;
        logic subtract;
    } t_alu_ctrl;

endpackage

>>> rtl/core/fenwick_tree_sum_engine_top.sv
// Top level of the binary indexed tree sum engine: sequencer, tree RAM and shared adder.
// Depends on fts_pkg, fts_ram and fts_alu.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+--------------------------------------
//  request  | in        | i_in_valid / o_in_ready      | i_op, i_first_index, i_second_index,
//           |           |                              | i_add_value
//  result   | out       | o_out_valid / i_out_ready    | o_sum_result
//  config   | in        | i_cfg_we (no wait)           | i_cfg_wdata (length in use)
//
// A tree walk visits k entries (k at most log2(TREE_SIZE) + 1), or none when no entry
// is in range; the RAM read port paces one entry per cycle. Point add and prefix sum run
// one walk, a range operation two; a query ends by loading the result register.
// Reset starts a clearing pass over all TREE_SIZE entries in which no request is taken.
// A waiting result stalls only a further query that finishes before it is taken.
`timescale 1ns / 1ps

module fenwick_tree_sum_engine_top
    import fts_pkg::*;
#(
    parameter int TREE_SIZE   = TREE_SIZE_DEFAULT,
    parameter int VALUE_WIDTH = VALUE_W_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_op,
    input  logic [IDX_W-1:0]         i_first_index,
    input  logic [IDX_W-1:0]         i_second_index,
    input  logic signed [IN_VALUE_W-1:0] i_add_value,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [VALUE_WIDTH-1:0] o_sum_result,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [LEN_W-1:0]         i_cfg_wdata
);

    // RAM address width, and position width wide enough for r + 1 and for the
    // overshoot of an update walk past the active length.
    localparam int AW = $clog2(TREE_SIZE);
    localparam int PW = ((IDX_W + 1) > (AW + 2)) ? (IDX_W + 1) : (AW + 2);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_RESULT
    } t_state;

    t_state                 r_state,       n_state;
    logic [LEN_W-1:0]       r_len,         n_len;
    t_op                    r_op,          n_op;
    logic [IDX_W-1:0]       r_first,       n_first;
    logic [IDX_W-1:0]       r_second,      n_second;
    logic [VALUE_WIDTH-1:0] r_value,       n_value;
    logic [VALUE_WIDTH-1:0] r_acc,         n_acc;
    logic [PW-1:0]          r_pos,         n_pos;
    logic                   r_pend,        n_pend;
    logic [PW-1:0]          r_pend_pos,    n_pend_pos;
    logic                   r_second_walk, n_second_walk;
    logic [AW-1:0]          r_clr_addr,    n_clr_addr;
    logic                   r_out_valid,   n_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_sum,     n_out_sum;

    logic [PW-1:0]          len_eff;
    logic                   upd_walk;
    logic                   in_range;
    logic [PW-1:0]          lowbit;
    logic [PW-1:0]          next_pos;
    logic [PW-1:0]          start_pos;
    logic [PW-1:0]          first_ext;
    logic [PW-1:0]          second_ext;
    logic [PW-1:0]          pos_m1;
    logic [PW-1:0]          pend_m1;
    logic                   two_walks;
    logic                   is_query;

    t_alu_ctrl              alu_ctrl;
    logic [VALUE_WIDTH-1:0] alu_sum;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    // Clamp a query position to the active length.
    function automatic logic [PW-1:0] clamp_len(input logic [PW-1:0] x,
                                                input logic [PW-1:0] lim);
        clamp_len = (x > lim) ? lim : x;
    endfunction

    // Walk geometry. Update walks climb by the lowest set bit and stop past the
    // active length; query walks descend to zero and are clamped at the start.
    always_comb begin
        len_eff    = (PW'(r_len) > PW'(TREE_SIZE)) ? PW'(TREE_SIZE) : PW'(r_len);
        upd_walk   = (r_op == OP_POINT_ADD) || (r_op == OP_RANGE_ADD);
        two_walks  = (r_op == OP_RANGE_SUM) || (r_op == OP_RANGE_ADD);
        is_query   = (r_op == OP_PREFIX) || (r_op == OP_RANGE_SUM);
        in_range   = (r_pos != '0) && (!upd_walk || (r_pos <= len_eff));
        lowbit     = r_pos & (~r_pos + PW'(1));
        next_pos   = upd_walk ? (r_pos + lowbit) : (r_pos - lowbit);
        first_ext  = PW'(r_first);
        second_ext = PW'(r_second);
        pos_m1     = r_pos - PW'(1);
        pend_m1    = r_pend_pos - PW'(1);

        unique case (r_op)
            OP_POINT_ADD: start_pos = first_ext;
            OP_PREFIX:    start_pos = clamp_len(first_ext, len_eff);
            OP_RANGE_SUM: begin
                if (!r_second_walk) begin
                    start_pos = clamp_len(second_ext, len_eff);
                end else if (r_first == '0) begin
                    start_pos = '0;
                end else begin
                    start_pos = clamp_len(first_ext - PW'(1), len_eff);
                end
            end
            OP_RANGE_ADD: begin
                if (r_second_walk) begin
                    start_pos = second_ext + PW'(1);
                end else if (r_first == '0) begin
                    start_pos = PW'(1);
                end else begin
                    start_pos = first_ext;
                end
            end
            default:      start_pos = '0;
        endcase
    end

    // The second walk of a range operation subtracts: it undoes the value past
    // the right end, or takes the lower prefix away from the upper one.
    assign alu_ctrl.update   = upd_walk;
    assign alu_ctrl.subtract = r_second_walk;

    fts_alu #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_alu (
        .i_ctrl  (alu_ctrl),
        .i_acc   (r_acc),
        .i_mem   (ram_rdata),
        .i_value (r_value),
        .o_sum   (alu_sum)
    );

    // Tree entry p lives at RAM address p - 1. The read for the next position is
    // issued in the same cycle as the write-back of the current one; positions in
    // an update walk strictly rise, so the two never collide.
    always_comb begin
        ram_we    = (r_state == ST_CLEAR) || ((r_state == ST_WALK) && r_pend && upd_walk);
        ram_waddr = (r_state == ST_CLEAR) ? r_clr_addr : pend_m1[AW-1:0];
        ram_wdata = (r_state == ST_CLEAR) ? '0 : alu_sum;
        ram_raddr = pos_m1[AW-1:0];
    end

    fts_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TREE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready = (r_state == ST_IDLE);

    // Sequencer.
    always_comb begin
        n_state       = r_state;
        n_len         = i_cfg_we ? i_cfg_wdata : r_len;
        n_op          = r_op;
        n_first       = r_first;
        n_second      = r_second;
        n_value       = r_value;
        n_acc         = r_acc;
        n_pos         = r_pos;
        n_pend        = r_pend;
        n_pend_pos    = r_pend_pos;
        n_second_walk = r_second_walk;
        n_clr_addr    = r_clr_addr;
        n_out_valid   = r_out_valid;
        n_out_sum     = r_out_sum;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(TREE_SIZE - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op          = t_op'(i_op);
                    n_first       = i_first_index;
                    n_second      = i_second_index;
                    n_value       = VALUE_WIDTH'(i_add_value);
                    n_acc         = '0;
                    n_second_walk = 1'b0;
                    n_state       = ST_START;
                end
            end
            ST_START: begin
                n_pos   = start_pos;
                n_pend  = 1'b0;
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (r_pend && !upd_walk) begin
                    n_acc = alu_sum;
                end
                n_pend = in_range;
                if (in_range) begin
                    n_pend_pos = r_pos;
                    n_pos      = next_pos;
                end else if (!r_pend) begin
                    if (two_walks && !r_second_walk) begin
                        n_second_walk = 1'b1;
                        n_state       = ST_START;
                    end else if (is_query) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = r_acc;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_first    <= n_first;
        r_second   <= n_second;
        r_value    <= n_value;
        r_acc      <= n_acc;
        r_pos      <= n_pos;
        r_pend_pos <= n_pend_pos;
        r_out_sum  <= n_out_sum;
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_len         <= LEN_RESET;
            r_pend        <= 1'b0;
            r_second_walk <= 1'b0;
            r_clr_addr    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_len         <= n_len;
            r_pend        <= n_pend;
            r_second_walk <= n_second_walk;
            r_clr_addr    <= n_clr_addr;
            r_out_valid   <= n_out_valid;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sum_result = r_out_sum;

endmodule

>>> rtl/core/fts_ram.sv
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module fts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/fts_alu.sv
// Shared add/subtract unit for tree walks: entry write-back or accumulation.
// Depends on fts_pkg for the control type.
`timescale 1ns / 1ps

module fts_alu
    import fts_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_W_DEFAULT
) (
    input  t_alu_ctrl              i_ctrl,
    input  logic [VALUE_WIDTH-1:0] i_acc,
    input  logic [VALUE_WIDTH-1:0] i_mem,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic [VALUE_WIDTH-1:0] o_sum
);

    logic [VALUE_WIDTH-1:0] opa;
    logic [VALUE_WIDTH-1:0] opb;

    always_comb begin
        opa = i_ctrl.update ? i_mem   : i_acc;
        opb = i_ctrl.update ? i_value : i_mem;
        o_sum = i_ctrl.subtract ? (opa - opb) : (opa + opb);
    end

endmodule

>>> rtl/core/fts_checker.sv
// Port-level checks for the binary indexed tree sum engine, bound to its top level.
// Depends on fts_pkg and on the port list of fenwick_tree_sum_engine_top.
`timescale 1ns / 1ps

module fts_checker
    import fts_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_W_DEFAULT
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic [VALUE_WIDTH-1:0]   o_sum_result
);

    // Reset starts the clearing pass, so no request is taken straight after it.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("request ready directly after reset");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid directly after reset");

    // One request at a time: an accepted transfer makes the block busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while the previous one is in progress");

    // A result only appears at the end of a walk, never out of the idle state.
    a_result_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a finished query");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_sum_result)))
        else $error("stalled result dropped or changed");

endmodule

bind fenwick_tree_sum_engine_top fts_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_fts_checker (.*);
